### design/mlfc_pkg.sv
`timescale 1ns / 1ps
// Shared types for the multilevel FIFO cache model.
// No dependencies.
package mlfc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    LVL_L1   = 3'd0,
    LVL_L2   = 3'd1,
    LVL_L3   = 3'd2,
    LVL_MEM  = 3'd3,
    LVL_DISK = 3'd4
  } lvl_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_CTIME = 2'd1,
    REG_MTIME = 2'd2,
    REG_DTIME = 2'd3
  } reg_idx_t;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned TIME_W = 11;
  localparam int unsigned CFG_W  = 8;

endpackage

### design/multilevel_fifo_cache_model.sv
`timescale 1ns / 1ps
// Multilevel fully associative FIFO cache model, top level.
// Depends on mlfc_pkg.
//
// Input channel in_valid/in_stall carries one key per transfer. Each key is
// searched in L1, then (mode 1) L2 and L3, then memory. All key stores share
// one synchronous memory; each level is scanned one entry per cycle up to
// its fill count. The result is registered soonest for an L1 hit on its
// first entry, or an empty L1 and memory in mode 0, and latest with all
// levels full and a disk access. On a miss the key is written at that
// level's round-robin pointer.
// One item is worked on at a time; in_stall is low only while idle. A
// finished result sits in the output register (out_valid/out_stall); the
// next key is taken while it waits, and the scan end holds until the output
// register frees. Reset (rst_n, synchronous) empties all stores through
// zeroed fill counts, so no clearing pass is needed, clears the totals and
// loads the register defaults: mode 1, cache 1, memory 10, disk 30 tenths.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// the user makes them only while idle, unchecked. Totals saturate at 2^32-1.
module multilevel_fifo_cache_model #(
  parameter int unsigned FIRST_LEVEL_ENTRIES  = 5,
  parameter int unsigned SECOND_LEVEL_ENTRIES = 20,
  parameter int unsigned THIRD_LEVEL_ENTRIES  = 200,
  parameter int unsigned MEMORY_ENTRIES       = 500,
  parameter int unsigned KEY_BITS             = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [KEY_BITS-1:0]            in_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_found_level,
  output logic [mlfc_pkg::TIME_W-1:0]    out_access_time,
  output logic [mlfc_pkg::CNT_W-1:0]     out_hit_total,
  output logic [mlfc_pkg::CNT_W-1:0]     out_miss_total,
  output logic [mlfc_pkg::CNT_W-1:0]     out_time_total,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [mlfc_pkg::CFG_W-1:0]     cfg_wdata
);
  import mlfc_pkg::*;

  localparam int unsigned TOTAL = FIRST_LEVEL_ENTRIES + SECOND_LEVEL_ENTRIES +
                                  THIRD_LEVEL_ENTRIES + MEMORY_ENTRIES;
  localparam int unsigned AW = $clog2(TOTAL);
  localparam int unsigned CW = $clog2(TOTAL + 1);
  localparam int unsigned BASE2 = FIRST_LEVEL_ENTRIES;
  localparam int unsigned BASE3 = BASE2 + SECOND_LEVEL_ENTRIES;
  localparam int unsigned BASEM = BASE3 + THIRD_LEVEL_ENTRIES;

  logic [KEY_BITS-1:0] mem [TOTAL];
  logic [KEY_BITS-1:0] rdata_r;
  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_raddr, mem_waddr;

  state_t              state_r, state_nxt;
  lvl_t                lvl_r, lvl_nxt;
  logic [2:0]          found_r, found_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [CNT_W-1:0]    hit_r, hit_nxt, miss_r, miss_nxt, tsum_r, tsum_nxt;
  logic [CW-1:0]       fill_r [4];
  logic [CW-1:0]       fill_nxt [4];
  logic [CW-1:0]       ptr_r [4];
  logic [CW-1:0]       ptr_nxt [4];
  logic                mode_r;
  logic [CFG_W-1:0]    ctime_r, mtime_r, dtime_r;
  logic                ovalid_r, ovalid_nxt;
  logic [2:0]          ofound_r, ofound_nxt;
  logic [TIME_W-1:0]   otime_r, otime_nxt;
  logic [CNT_W-1:0]    ohit_r, ohit_nxt, omiss_r, omiss_nxt, otot_r, otot_nxt;

  logic [CW-1:0]       lsize;
  logic [AW-1:0]       lbase;
  logic [1:0]          sel;
  logic                hit;
  logic                out_free;
  logic [CNT_W:0]      tsum_sum;

  assign sel      = lvl_r[1:0];
  assign out_free = !ovalid_r || !out_stall;
  assign hit      = pend_r && (rdata_r == key_r) && (key_r != '0);
  assign tsum_sum = {1'b0, tsum_r} + (CNT_W + 1)'(t_r);

  always_comb begin
    case (lvl_r)
      LVL_L1:  begin lsize = CW'(FIRST_LEVEL_ENTRIES);  lbase = '0;         end
      LVL_L2:  begin lsize = CW'(SECOND_LEVEL_ENTRIES); lbase = AW'(BASE2); end
      LVL_L3:  begin lsize = CW'(THIRD_LEVEL_ENTRIES);  lbase = AW'(BASE3); end
      default: begin lsize = CW'(MEMORY_ENTRIES);       lbase = AW'(BASEM); end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    lvl_nxt    = lvl_r;
    found_nxt  = found_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    key_nxt    = key_r;
    t_nxt      = t_r;
    hit_nxt    = hit_r;
    miss_nxt   = miss_r;
    tsum_nxt   = tsum_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    ovalid_nxt = ovalid_r && out_stall;
    ofound_nxt = ofound_r;
    otime_nxt  = otime_r;
    ohit_nxt   = ohit_r;
    omiss_nxt  = omiss_r;
    otot_nxt   = otot_r;
    mem_re     = 1'b0;
    mem_raddr  = lbase + AW'(idx_r);
    mem_we     = 1'b0;
    mem_waddr  = lbase + AW'(ptr_r[sel]);
    in_stall   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          key_nxt   = in_key;
          lvl_nxt   = LVL_L1;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          t_nxt     = TIME_W'(ctime_r);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          hit_nxt   = (hit_r == '1) ? hit_r : hit_r + 1'b1;
          found_nxt = lvl_r;
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else if (idx_r < fill_r[sel]) begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          // last compare still in flight
          pend_nxt = 1'b0;
        end else begin
          // miss: write at round-robin pointer, move down
          mem_we         = 1'b1;
          miss_nxt       = (miss_r == '1) ? miss_r : miss_r + 1'b1;
          ptr_nxt[sel]   = (ptr_r[sel] + 1'b1 == lsize) ? '0 : ptr_r[sel] + 1'b1;
          fill_nxt[sel]  = (fill_r[sel] == lsize) ? fill_r[sel] : fill_r[sel] + 1'b1;
          idx_nxt        = '0;
          case (lvl_r)
            LVL_L1: begin
              if (mode_r) begin
                lvl_nxt = LVL_L2;
                t_nxt   = t_r + TIME_W'(ctime_r);
              end else begin
                lvl_nxt = LVL_MEM;
                t_nxt   = t_r + TIME_W'(mtime_r);
              end
            end
            LVL_L2: begin
              lvl_nxt = LVL_L3;
              t_nxt   = t_r + TIME_W'(ctime_r);
            end
            LVL_L3: begin
              lvl_nxt = LVL_MEM;
              t_nxt   = t_r + TIME_W'(mtime_r);
            end
            default: begin
              t_nxt     = t_r + TIME_W'(dtime_r);
              found_nxt = LVL_DISK;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          tsum_nxt   = tsum_sum[CNT_W] ? '1 : tsum_sum[CNT_W-1:0];
          ovalid_nxt = 1'b1;
          ofound_nxt = found_r;
          otime_nxt  = t_r;
          ohit_nxt   = hit_r;
          omiss_nxt  = miss_r;
          otot_nxt   = tsum_nxt;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= key_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    t_r      <= t_nxt;
    ofound_r <= ofound_nxt;
    otime_r  <= otime_nxt;
    ohit_r   <= ohit_nxt;
    omiss_r  <= omiss_nxt;
    otot_r   <= otot_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      lvl_r    <= LVL_L1;
      pend_r   <= 1'b0;
      hit_r    <= '0;
      miss_r   <= '0;
      tsum_r   <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        fill_r[i] <= '0;
        ptr_r[i]  <= '0;
      end
      mode_r  <= 1'b1;
      ctime_r <= CFG_W'(1);
      mtime_r <= CFG_W'(10);
      dtime_r <= CFG_W'(30);
    end else begin
      state_r  <= state_nxt;
      lvl_r    <= lvl_nxt;
      pend_r   <= pend_nxt;
      hit_r    <= hit_nxt;
      miss_r   <= miss_nxt;
      tsum_r   <= tsum_nxt;
      ovalid_r <= ovalid_nxt;
      fill_r   <= fill_nxt;
      ptr_r    <= ptr_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:  mode_r  <= cfg_wdata[0];
          REG_CTIME: ctime_r <= cfg_wdata;
          REG_MTIME: mtime_r <= cfg_wdata;
          REG_DTIME: dtime_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid       = ovalid_r;
  assign out_found_level = ofound_r;
  assign out_access_time = otime_r;
  assign out_hit_total   = ohit_r;
  assign out_miss_total  = omiss_r;
  assign out_time_total  = otot_r;

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted key did not start a scan");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found_level <= LVL_DISK))
    else $error("found level out of range");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN))
    else $error("read outstanding outside a scan");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write in one cycle");

endmodule

### verif/tb_multilevel_fifo_cache_model.sv
`timescale 1ns / 1ps
// Self-checking bench for the multilevel FIFO cache model: a cache predictor
// class mirrors the level stores and totals. Depends on mlfc_pkg and the RTL.
module tb_multilevel_fifo_cache_model;
  import mlfc_pkg::*;

  localparam int L1_N = 5;
  localparam int L2_N = 20;
  localparam int L3_N = 200;
  localparam int MEM_N = 500;
  localparam int KEY_W = 16;

  typedef struct packed {
    lvl_t             level;
    logic [TIME_W-1:0] acc_time;
    logic [31:0]      hits;
    logic [31:0]      misses;
    logic [31:0]      time_sum;
  } access_res_t;

  class cache_predictor;
    logic [KEY_W-1:0] l1[L1_N];
    logic [KEY_W-1:0] l2[L2_N];
    logic [KEY_W-1:0] l3[L3_N];
    logic [KEY_W-1:0] mem[MEM_N];
    int unsigned p1, p2, p3, pm;
    logic [31:0] hits, misses, tsum;
    logic mode;
    logic [7:0] ctime, mtime, dtime;
    access_res_t pending[$];
    int errors;

    function void clear();
      foreach (l1[i]) l1[i] = '0;
      foreach (l2[i]) l2[i] = '0;
      foreach (l3[i]) l3[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      p1 = 0; p2 = 0; p3 = 0; pm = 0;
      hits = 0; misses = 0; tsum = 0;
      mode = 1'b1; ctime = 8'd1; mtime = 8'd10; dtime = 8'd30;
      errors = 0;
    endfunction

    function logic [31:0] sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void write_reg(reg_idx_t idx, logic [7:0] v);
      case (idx)
        REG_MODE:  mode = v[0];
        REG_CTIME: ctime = v;
        REG_MTIME: mtime = v;
        REG_DTIME: dtime = v;
        default: ;
      endcase
    endfunction

    // Fixed-size stores are selected via a per-level case.
    function bit lookup(int lv, logic [KEY_W-1:0] k);
      bit hit;
      hit = 0;
      if (k != 0) begin
        case (lv)
          0: foreach (l1[i]) if (l1[i] == k) hit = 1;
          1: foreach (l2[i]) if (l2[i] == k) hit = 1;
          2: foreach (l3[i]) if (l3[i] == k) hit = 1;
          default: foreach (mem[i]) if (mem[i] == k) hit = 1;
        endcase
      end
      if (hit) begin
        hits = sat(hits, 1);
        return 1;
      end
      misses = sat(misses, 1);
      case (lv)
        0: begin l1[p1] = k; p1 = (p1 + 1 >= L1_N) ? 0 : p1 + 1; end
        1: begin l2[p2] = k; p2 = (p2 + 1 >= L2_N) ? 0 : p2 + 1; end
        2: begin l3[p3] = k; p3 = (p3 + 1 >= L3_N) ? 0 : p3 + 1; end
        default: begin mem[pm] = k; pm = (pm + 1 >= MEM_N) ? 0 : pm + 1; end
      endcase
      return 0;
    endfunction

    function void note_key(logic [KEY_W-1:0] k);
      access_res_t r;
      int unsigned t;
      bit done;
      t = ctime;
      done = 0;
      if (lookup(0, k)) begin
        r.level = LVL_L1;
        done = 1;
      end else if (mode) begin
        t += ctime;
        if (lookup(1, k)) begin
          r.level = LVL_L2;
          done = 1;
        end else begin
          t += ctime;
          if (lookup(2, k)) begin
            r.level = LVL_L3;
            done = 1;
          end
        end
      end
      if (!done) begin
        t += mtime;
        r.level = LVL_MEM;
        if (!lookup(3, k)) begin
          t += dtime;
          r.level = LVL_DISK;
        end
      end
      tsum = sat(tsum, t);
      r.acc_time = t[TIME_W-1:0];
      r.hits = hits;
      r.misses = misses;
      r.time_sum = tsum;
      pending.push_back(r);
    endfunction

    function void check_result(access_res_t got);
      access_res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.level !== exp.level)
        $display("%0t: level exp %0d got %0d", $time, exp.level, got.level);
      if (got.acc_time !== exp.acc_time)
        $display("%0t: access time exp %0d got %0d", $time, exp.acc_time, got.acc_time);
      if (got.hits !== exp.hits)
        $display("%0t: hits exp %0d got %0d", $time, exp.hits, got.hits);
      if (got.misses !== exp.misses)
        $display("%0t: misses exp %0d got %0d", $time, exp.misses, got.misses);
      if (got.time_sum !== exp.time_sum)
        $display("%0t: time total exp %0d got %0d", $time, exp.time_sum, got.time_sum);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [KEY_W-1:0] in_key;
  logic out_valid, out_stall;
  logic [2:0] out_found_level;
  logic [TIME_W-1:0] out_access_time;
  logic [CNT_W-1:0] out_hit_total, out_miss_total, out_time_total;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  cache_predictor model;
  bit calm;
  logic [KEY_W-1:0] recent[$];

  multilevel_fifo_cache_model u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_key(in_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found_level(out_found_level), .out_access_time(out_access_time),
    .out_hit_total(out_hit_total), .out_miss_total(out_miss_total),
    .out_time_total(out_time_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

  // Sample results at the rising edge; vary stall at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      model.check_result({lvl_t'(out_found_level), out_access_time,
                          out_hit_total, out_miss_total, out_time_total});
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 15);
  end

  // Valid stays up after the transfer until the next falling edge, where
  // the next key or an idle cycle replaces it.
  task automatic send_key(logic [KEY_W-1:0] k);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_key <= k;
    do @(posedge clk); while (in_stall);
    model.note_key(k);
    recent.push_back(k);
    if (recent.size() > 300) void'(recent.pop_front());
  endtask

  task automatic set_reg(reg_idx_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    model.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (model.pending.size() != 0) @(negedge clk);
    repeat (800) @(negedge clk);
  endtask

  // Mostly reuse of recent keys so every level hits; some fresh keys.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (recent.size() > 0 && r < 60)
      return recent[$urandom_range(recent.size() - 1)];
    if (r < 75) return KEY_W'($urandom_range(40, 1));
    if (r < 77) return 16'hFFFF;
    if (r < 78) return 16'h0000;
    return KEY_W'($urandom_range(65535, 1));
  endfunction

  initial begin
    model = new();
    model.clear();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, key zero, duplicates across levels.
    send_key(16'h0001);
    send_key(16'hFFFF);
    send_key(16'h0000);
    send_key(16'h0001);
    send_key(16'hFFFF);
    for (int i = 2; i <= 8; i++) send_key(i[KEY_W-1:0]);
    send_key(16'h0001);
    send_key(16'h0001);
    send_key(16'h5555);
    send_key(16'hAAAA);
    drain();
    set_reg(REG_MODE, 8'h00);
    set_reg(REG_CTIME, 8'hFF);
    set_reg(REG_MTIME, 8'hFF);
    set_reg(REG_DTIME, 8'hFF);
    send_key(16'h0001);
    send_key(16'h1234);
    send_key(16'h0000);
    send_key(16'h1234);
    drain();
    set_reg(REG_MODE, 8'hFF);
    send_key(16'h0002);
    send_key(16'h0000);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          set_reg(REG_MODE, 8'h01); set_reg(REG_CTIME, 8'h00);
          set_reg(REG_MTIME, 8'h00); set_reg(REG_DTIME, 8'h00);
        end
        1: begin
          set_reg(REG_MODE, 8'h00); set_reg(REG_CTIME, 8'($urandom_range(255)));
          set_reg(REG_MTIME, 8'($urandom_range(255)));
          set_reg(REG_DTIME, 8'($urandom_range(255)));
        end
        2: begin
          set_reg(REG_MODE, 8'hFE); set_reg(REG_CTIME, 8'd1);
          set_reg(REG_MTIME, 8'd10); set_reg(REG_DTIME, 8'd30);
        end
        default: begin
          set_reg(REG_MODE, 8'h01); set_reg(REG_CTIME, 8'hFF);
          set_reg(REG_MTIME, 8'hFF); set_reg(REG_DTIME, 8'hFF);
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        calm = (phase == 2) && (n >= 50) && (n < 130);
        send_key(pick_key());
      end
      calm = 1'b0;
    end

    drain();
    if (model.errors == 0 && model.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### sim.f
design/mlfc_pkg.sv
design/multilevel_fifo_cache_model.sv
verif/tb_multilevel_fifo_cache_model.sv
